### design/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg: shared definitions for the trial division primality block
// Widths, divisor constants, state encoding and the remainder unit interface.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    localparam int FIRST_DIV   = 5;
    localparam int DIV_STEP    = 6;
    localparam int PAIR_OFFSET = 2;
    localparam int THIRD_DIV   = 3;

    // The square of d grows by 12*d + 36 per pass; that increment grows by 72.
    localparam int FIRST_SQ    = FIRST_DIV * FIRST_DIV;
    localparam int FIRST_INC   = 2 * DIV_STEP * FIRST_DIV + DIV_STEP * DIV_STEP;
    localparam int INC_STEP    = 2 * DIV_STEP * DIV_STEP;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [SQ_WIDTH-1:0]    square_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT3,
        ST_LOOP,
        ST_WAIT_D,
        ST_WAIT_D2,
        ST_DONE
    } state_t;

endpackage

### design/tdp_rem.sv
// ----------------------------------------------------------------------------
// tdp_rem: bit-serial remainder unit
// Restoring division that shifts in one dividend bit per cycle and reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdp_rem
    import tdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rem_req_t    req,
    output rem_status_t status
);

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    value_t               dvd_reg, dvd_next;
    value_t               div_reg, div_next;
    value_t               rem_reg, rem_next;
    logic [VALUE_WIDTH:0] shifted;
    logic [VALUE_WIDTH:0] diff;

    always_comb
    begin
        shifted     = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        diff        = shifted - {1'b0, div_reg};
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_WIDTH'(VALUE_WIDTH);
            dvd_next    = req.dividend;
            div_next    = req.divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = diff[VALUE_WIDTH] ? shifted[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

    a_done_not_active: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !active_reg)
        else $error("remainder done while still shifting");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.start && active_reg))
        else $error("remainder started while busy");

endmodule

### design/trial_division_primality_top.sv
// ----------------------------------------------------------------------------
// trial_division_primality_top: primality test by 6k +/- 1 trial division
// Values settled without a divisor need no remainder; the rest are tried against
// three and then against each divisor pair d, d + 2 in the bit-serial unit,
// one remainder at a time. One word is in work at a time, the next is taken
// in the cycle after the result is registered, and a result that waits on
// m_tready holds the block. Reset (rst_n, asynchronous, active low) empties
// the block and its output.
// ----------------------------------------------------------------------------
module trial_division_primality_top
    import tdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,   // value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // is_prime, then zero fill
);

    state_t      state_reg, state_next;
    value_t      n_reg, n_next;
    value_t      d_reg, d_next;
    square_t     sq_reg, sq_next;
    square_t     inc_reg, inc_next;
    logic        res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_prime_reg, out_prime_next;
    rem_req_t    req;
    rem_status_t status;

    tdp_rem u_rem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .status (status)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        inc_next       = inc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        req.start      = 1'b0;
        req.dividend   = n_reg;
        req.divisor    = VALUE_WIDTH'(THIRD_DIV);
        s_tready       = (state_reg == ST_IDLE);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next     = s_tdata[VALUE_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                d_next   = VALUE_WIDTH'(FIRST_DIV);
                sq_next  = SQ_WIDTH'(FIRST_SQ);
                inc_next = SQ_WIDTH'(FIRST_INC);
                if (n_reg[VALUE_WIDTH-1] || n_reg <= VALUE_WIDTH'(1))
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg <= VALUE_WIDTH'(THIRD_DIV))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = ST_WAIT3;
                end
            end
            ST_WAIT3:
            begin
                if (status.done)
                begin
                    if (status.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_LOOP:
            begin
                if (sq_reg > SQ_WIDTH'(n_reg))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    req.start   = 1'b1;
                    req.divisor = d_reg;
                    state_next  = ST_WAIT_D;
                end
            end
            ST_WAIT_D:
            begin
                req.divisor = d_reg + VALUE_WIDTH'(PAIR_OFFSET);
                if (status.done)
                begin
                    if (status.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        state_next = ST_WAIT_D2;
                    end
                end
            end
            ST_WAIT_D2:
            begin
                if (status.done)
                begin
                    if (status.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(DIV_STEP);
                        sq_next    = sq_reg + inc_reg;
                        inc_next   = inc_reg + SQ_WIDTH'(INC_STEP);
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        inc_reg       <= inc_next;
        res_reg       <= res_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_prime_reg};

    a_negative_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_reg) |-> !n_reg[VALUE_WIDTH-1])
        else $error("negative value reported prime");

    a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> d_reg[0])
        else $error("trial divisor is even");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the trial division primality block
// Sends signed 32-bit words, predicts each prime verdict with its own 6k +/- 1
// trial division, and compares every result word in order. Both sides idle in
// random bursts, except during a quiet tail at the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
    import tdp_pkg::*;

    localparam int RANDOM_WORDS = 78;
    localparam int TAIL_WORDS   = 15;
    localparam int STALL_LIMIT  = 2000000;
    localparam int SETTLE_TICKS = 20;

    typedef struct {
        value_t value;
        bit     drain_first;
    } test_word_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;

    test_word_t words_to_test[$];
    bit         verdicts_due[$];
    int         words_sent   = 0;
    int         words_seen   = 0;
    int         send_gap     = 0;
    int         recv_gap     = 0;
    int         stall_cycles = 0;
    int         errors       = 0;
    bit         tail_phase   = 1'b0;

    trial_division_primality_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit prime_verdict(value_t v);
        longint unsigned n;
        longint unsigned d;
        bit              verdict;
        n = v;
        verdict = 1'b1;
        if (v[VALUE_WIDTH-1] || n <= 1)
            verdict = 1'b0;
        else if (n <= THIRD_DIV)
            verdict = 1'b1;
        else if (n % PAIR_OFFSET == 0 || n % THIRD_DIV == 0)
            verdict = 1'b0;
        else
        begin
            for (d = FIRST_DIV; d * d <= n && verdict; d += DIV_STEP)
            begin
                if (n % d == 0 || n % (d + PAIR_OFFSET) == 0)
                    verdict = 1'b0;
            end
        end
        return verdict;
    endfunction

    task automatic queue_word(value_t v, bit drain);
        test_word_t w;
        w.value = v;
        w.drain_first = drain;
        words_to_test = {words_to_test, w};
    endtask

    // Sender: presents one word at a time and records the verdict it should get.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
            words_sent <= 0;
            tail_phase <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid && s_tready)
            begin
                verdicts_due = {verdicts_due, prime_verdict(s_tdata[VALUE_WIDTH-1:0])};
                words_sent <= words_sent + 1;
            end
            tail_phase <= (words_to_test.size() <= TAIL_WORDS);
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (words_to_test.size() == 0)
                s_tvalid <= 1'b0;
            else if (words_to_test[0].drain_first
                     && (words_sent != words_seen || (s_tvalid && s_tready)))
                s_tvalid <= 1'b0;
            else if (words_to_test.size() > TAIL_WORDS && $urandom_range(0, 4) == 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= words_to_test[0].value;
                void'(words_to_test.pop_front());
            end
        end
    end

    // Receiver: checks each result word against the oldest pending verdict.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            words_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen <= words_seen + 1;
                if (verdicts_due.size() == 0)
                begin
                    $error("is_prime: no result expected, got %0d", m_tdata[0]);
                    errors <= errors + 1;
                end
                else
                begin
                    bit want;
                    want = verdicts_due.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        $error("is_prime: expected %0d, got %0d", want, m_tdata[0]);
                        errors <= errors + 1;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!tail_phase && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 6);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned small_primes[5];
        int unsigned p;
        int unsigned a;
        value_t      v;
        small_primes = '{3, 5, 7, 11, 13};

        queue_word(32'd0, 1'b0);
        queue_word(32'd1, 1'b0);
        queue_word(32'd2, 1'b0);
        queue_word(32'd3, 1'b0);
        queue_word(32'd4, 1'b0);
        queue_word(32'd5, 1'b0);
        queue_word(32'd7, 1'b0);
        queue_word(32'd9, 1'b0);
        queue_word(32'd24, 1'b0);
        queue_word(32'd25, 1'b0);
        queue_word(32'd35, 1'b0);
        queue_word(32'd49, 1'b0);
        queue_word(32'd143, 1'b0);
        queue_word(32'd169, 1'b0);
        queue_word(32'd289, 1'b0);
        queue_word(32'd97, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'hFFFF_FFF9, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h7FFF_FFFE, 1'b0);
        queue_word(32'h7FFF_FFFD, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = $urandom_range(0, 1 << 14);
                5: v = $urandom_range(0, 1 << 20);
                6: v = $urandom() | 32'h8000_0000;
                7: v = $urandom() & 32'h7FFF_FFFE;
                8:
                begin
                    p = small_primes[$urandom_range(0, 4)];
                    v = p * $urandom_range(1, 32'h7FFF_FFFF / p);
                end
                default:
                begin
                    a = 2 * $urandom_range(2, 500) + 1;
                    v = a * (a + PAIR_OFFSET * $urandom_range(0, 1));
                end
            endcase
            queue_word(v, i == 0 || i == RANDOM_WORDS / 2);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (words_to_test.size() != 0 || s_tvalid || words_seen != words_sent);
        repeat (SETTLE_TICKS) @(negedge clk);

        if (errors == 0 && verdicts_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

### trial_division_primality_top.f
design/tdp_pkg.sv
design/tdp_rem.sv
design/trial_division_primality_top.sv
tb/sv/tb_top.sv
